>>> rtl/ldpm_pkg.sv
// ----------------------------------------------------------------------------
// ldpm_pkg
// Types and constants shared by the lens distortion point map pipeline.
// ----------------------------------------------------------------------------
package ldpm_pkg;

  localparam int FRAC     = 20;   // fraction bits of normalized values
  localparam int NORM_W   = 23;   // normalized coordinate, +-4.0 in Q.20
  localparam int COEF_W   = 24;   // Q8.16 coefficients
  localparam int CENTER_W = 14;
  localparam int FOCAL_W  = 16;
  localparam int MID_W    = 24;   // intermediate point after radial stage
  localparam int OUT_W    = 16;
  localparam int CFG_IDX_W = 4;

  typedef logic signed [NORM_W-1:0] norm_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [CENTER_W-1:0]      center_t;
  typedef logic [FOCAL_W-1:0]       focal_t;
  typedef logic signed [MID_W-1:0]  mid_t;
  typedef logic signed [OUT_W-1:0]  out_t;

  localparam norm_t NORM_MAX = norm_t'((1 << (NORM_W - 1)) - 1);
  localparam norm_t NORM_MIN = norm_t'(1 << (NORM_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 4'd0,
    REG_CENTER_Y = 4'd1,
    REG_FOCAL    = 4'd2,
    REG_K1       = 4'd3,
    REG_K2       = 4'd4,
    REG_K3       = 4'd5,
    REG_P1       = 4'd6,
    REG_P2       = 4'd7
  } cfg_reg_t;

  // camera model as seen by the datapath, focal length already nonzero
  typedef struct packed {
    center_t center_x;
    center_t center_y;
    focal_t  focal;
    coef_t   k1;
    coef_t   k2;
    coef_t   k3;
    coef_t   p1;
    coef_t   p2;
  } cam_t;

endpackage

>>> rtl/ldpm_norm.sv
// ----------------------------------------------------------------------------
// ldpm_norm
// Pipelined normalization of a point pair: n = round(d * 2^20 / f),
// one quotient bit per stage, saturated to the normalized range.
// ----------------------------------------------------------------------------
module ldpm_norm #(
  parameter int DW = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic                  in_clip,
  input  logic signed [DW-1:0]  dx,
  input  logic signed [DW-1:0]  dy,
  input  ldpm_pkg::focal_t      f,
  output logic                  out_valid,
  output logic                  out_clip,
  output ldpm_pkg::norm_t       nx,
  output ldpm_pkg::norm_t       ny
);
  import ldpm_pkg::*;

  localparam int NW = DW + FRAC + 1;
  localparam int QB = NORM_W;

  logic signed [DW-1:0] dsel [0:1];
  logic [DW-1:0]        mag  [0:1];
  logic [NW-1:0]        num  [0:1];
  logic                 pneg [0:1];
  logic                 pvld;
  logic                 pclp;

  logic [FOCAL_W-1:0] rem [0:QB][0:1];
  logic [QB-1:0]      low [0:QB][0:1];
  logic [QB-1:0]      quo [0:QB][0:1];
  logic               ovf [0:QB][0:1];
  logic               neg [0:QB][0:1];
  logic               vld [0:QB];
  logic               clp [0:QB];

  norm_t res [0:1];
  logic  sat [0:1];

  assign dsel[0] = dx;
  assign dsel[1] = dy;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      mag[c] = dsel[c][DW-1] ? DW'(-dsel[c]) : DW'(dsel[c]);
    end
  end

  // numerator with half divisor added for round to nearest
  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= 1'b0;
    end else if (en) begin
      pvld <= in_valid;
    end
    if (en) begin
      pclp <= in_clip;
      for (int c = 0; c < 2; c++) begin
        num[c]  <= NW'({mag[c], {FRAC{1'b0}}}) + NW'(f >> 1);
        pneg[c] <= dsel[c][DW-1];
      end
    end
  end

  // quotient at or above 2^23 is out of range anyway
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= pvld;
    end
    if (en) begin
      clp[0] <= pclp;
      for (int c = 0; c < 2; c++) begin
        ovf[0][c] <= num[c][NW-1:QB] >= (NW-QB)'(f);
        rem[0][c] <= num[c][QB+FOCAL_W-1:QB];
        low[0][c] <= num[c][QB-1:0];
        quo[0][c] <= '0;
        neg[0][c] <= pneg[c];
      end
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [FOCAL_W:0] trial [0:1];
    logic             ge    [0:1];

    always_comb begin
      for (int c = 0; c < 2; c++) begin
        trial[c] = {rem[k-1][c], low[k-1][c][QB-1]};
        ge[c]    = trial[c] >= {1'b0, f};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        clp[k] <= clp[k-1];
        for (int c = 0; c < 2; c++) begin
          rem[k][c] <= ge[c] ? FOCAL_W'(trial[c] - {1'b0, f}) : trial[c][FOCAL_W-1:0];
          low[k][c] <= low[k-1][c] << 1;
          quo[k][c] <= {quo[k-1][c][QB-2:0], ge[c]};
          ovf[k][c] <= ovf[k-1][c];
          neg[k][c] <= neg[k-1][c];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if (neg[QB][c]) begin
        sat[c] = ovf[QB][c] || (quo[QB][c] > {1'b1, {(QB-1){1'b0}}});
        res[c] = sat[c] ? NORM_MIN : norm_t'(-quo[QB][c]);
      end else begin
        sat[c] = ovf[QB][c] || quo[QB][c][QB-1];
        res[c] = sat[c] ? NORM_MAX : norm_t'(quo[QB][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QB];
    end
    if (en) begin
      out_clip <= clp[QB] | sat[0] | sat[1];
      nx       <= res[0];
      ny       <= res[1];
    end
  end

endmodule

>>> rtl/ldpm_radial.sv
// ----------------------------------------------------------------------------
// ldpm_radial
// Radial correction: scales the normalized point by 1 + k1 r2 + k2 r4 + k3 r6
// and maps it back to 1/16 pixel units. Thirteen stages.
// ----------------------------------------------------------------------------
module ldpm_radial (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ldpm_pkg::cam_t   cam,
  input  logic             in_valid,
  input  logic             in_clip,
  input  ldpm_pkg::norm_t  nx,
  input  ldpm_pkg::norm_t  ny,
  output logic             out_valid,
  output logic             out_clip,
  output ldpm_pkg::mid_t   mx,
  output ldpm_pkg::mid_t   my
);
  import ldpm_pkg::*;

  logic [11:0] vld;
  logic [11:0] clp;

  logic signed [16:0] fs;
  assign fs = $signed({1'b0, cam.focal});

  norm_t s1_nx, s1_ny, s2_nx, s2_ny, s3_nx, s3_ny, s4_nx, s4_ny;
  norm_t s5_nx, s5_ny, s6_nx, s6_ny, s7_nx, s7_ny, s8_nx, s8_ny, s9_nx, s9_ny;
  logic signed [45:0] s1_pxx, s1_pyy;
  logic signed [26:0] s2_r2, s3_r2, s4_r2;
  logic signed [53:0] s3_pr4;
  logic signed [50:0] s3_t1, s4_t1, s5_t1;
  logic signed [31:0] s4_r4;
  logic signed [58:0] s5_pr6;
  logic signed [55:0] s5_t2;
  logic signed [36:0] s6_r6;
  logic signed [56:0] s6_s12, s7_s12;
  logic signed [60:0] s7_t3;
  logic signed [61:0] s8_sum;
  logic signed [31:0] s9_fac;
  logic signed [54:0] s10_px, s10_py;
  logic signed [34:0] s11_mx, s11_my;
  logic signed [51:0] s12_px, s12_py;

  // combinational helpers
  logic signed [45:0] rxx, ryy;
  logic signed [25:0] x2, y2;
  logic signed [53:0] rr4;
  logic signed [58:0] rr6;
  logic signed [61:0] rsum;
  logic signed [45:0] kterm;
  logic signed [46:0] facw;
  logic               fac_clip;
  logic signed [54:0] rmx, rmy;
  logic signed [51:0] rpx, rpy;
  logic signed [31:0] dpx, dpy;
  logic signed [32:0] wx, wy;
  logic               clip_x, clip_y;
  mid_t               satx, saty;

  always_comb begin
    rxx  = s1_pxx + 46'sd524288;
    ryy  = s1_pyy + 46'sd524288;
    x2   = rxx[45:20];
    y2   = ryy[45:20];
    rr4  = s3_pr4 + 54'sd524288;
    rr6  = s5_pr6 + 59'sd524288;
    rsum = s8_sum + 62'sd32768;
    kterm = rsum[61:16];
    facw = 47'(kterm) + 47'sd1048576;
    fac_clip = 1'b0;
    if (facw > 47'sd1073741824) begin
      fac_clip = 1'b1;
    end else if (facw < -47'sd1073741824) begin
      fac_clip = 1'b1;
    end
    rmx = s10_px + 55'sd524288;
    rmy = s10_py + 55'sd524288;
    rpx = s12_px + 52'sd524288;
    rpy = s12_py + 52'sd524288;
    dpx = rpx[51:20];
    dpy = rpy[51:20];
    wx  = $signed(33'(cam.center_x)) + 33'(dpx);
    wy  = $signed(33'(cam.center_y)) - 33'(dpy);
    clip_x = 1'b1;
    if (wx > 33'sd8388607) begin
      satx = mid_t'((1 << (MID_W - 1)) - 1);
    end else if (wx < -33'sd8388608) begin
      satx = mid_t'(1 << (MID_W - 1));
    end else begin
      satx = wx[MID_W-1:0];
      clip_x = 1'b0;
    end
    clip_y = 1'b1;
    if (wy > 33'sd8388607) begin
      saty = mid_t'((1 << (MID_W - 1)) - 1);
    end else if (wy < -33'sd8388608) begin
      saty = mid_t'(1 << (MID_W - 1));
    end else begin
      saty = wy[MID_W-1:0];
      clip_y = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[10:0], in_valid};
      out_valid <= vld[11];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // factor saturation joins the clip flag where the sum is formed
      clp    <= {clp[10:8], clp[7] | fac_clip, clp[6:0], in_clip};
      s1_nx  <= nx;
      s1_ny  <= ny;
      s1_pxx <= nx * nx;
      s1_pyy <= ny * ny;
      s2_nx  <= s1_nx;
      s2_ny  <= s1_ny;
      s2_r2  <= 27'(x2) + 27'(y2);
      s3_nx  <= s2_nx;
      s3_ny  <= s2_ny;
      s3_r2  <= s2_r2;
      s3_pr4 <= s2_r2 * s2_r2;
      s3_t1  <= $signed(cam.k1) * s2_r2;
      s4_nx  <= s3_nx;
      s4_ny  <= s3_ny;
      s4_r2  <= s3_r2;
      s4_r4  <= rr4[51:20];
      s4_t1  <= s3_t1;
      s5_nx  <= s4_nx;
      s5_ny  <= s4_ny;
      s5_pr6 <= s4_r4 * s4_r2;
      s5_t2  <= $signed(cam.k2) * s4_r4;
      s5_t1  <= s4_t1;
      s6_nx  <= s5_nx;
      s6_ny  <= s5_ny;
      s6_r6  <= rr6[56:20];
      s6_s12 <= 57'(s5_t1) + 57'(s5_t2);
      s7_nx  <= s6_nx;
      s7_ny  <= s6_ny;
      s7_t3  <= $signed(cam.k3) * s6_r6;
      s7_s12 <= s6_s12;
      s8_nx  <= s7_nx;
      s8_ny  <= s7_ny;
      s8_sum <= 62'(s7_s12) + 62'(s7_t3);
      s9_nx  <= s8_nx;
      s9_ny  <= s8_ny;
      if (facw > 47'sd1073741824) begin
        s9_fac <= 32'sd1073741824;
      end else if (facw < -47'sd1073741824) begin
        s9_fac <= -32'sd1073741824;
      end else begin
        s9_fac <= facw[31:0];
      end
      s10_px <= s9_nx * s9_fac;
      s10_py <= s9_ny * s9_fac;
      s11_mx <= rmx[54:20];
      s11_my <= rmy[54:20];
      s12_px <= s11_mx * fs;
      s12_py <= s11_my * fs;
      mx       <= satx;
      my       <= saty;
      out_clip <= clp[11] | clip_x | clip_y;
    end
  end

endmodule

>>> rtl/ldpm_tangent.sv
// ----------------------------------------------------------------------------
// ldpm_tangent
// Tangential correction with p1 and p2, back to 1/16 pixel units, saturated
// to the output range. Eight stages, the last one is the output register.
// ----------------------------------------------------------------------------
module ldpm_tangent (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ldpm_pkg::cam_t   cam,
  input  logic             in_valid,
  input  logic             in_clip,
  input  ldpm_pkg::norm_t  nx,
  input  ldpm_pkg::norm_t  ny,
  output logic             out_valid,
  output logic             out_clip,
  output ldpm_pkg::out_t   ox,
  output ldpm_pkg::out_t   oy
);
  import ldpm_pkg::*;

  logic [6:0] vld;
  logic [6:0] clp;

  logic signed [16:0] fs;
  assign fs = $signed({1'b0, cam.focal});

  norm_t s1_nx, s1_ny, s2_nx, s2_ny, s3_nx, s3_ny, s4_nx, s4_ny, s5_nx, s5_ny;
  logic signed [45:0] s1_pxx, s1_pyy, s1_pxy;
  logic signed [25:0] s2_x2, s2_y2, s2_xy, s3_xy;
  logic signed [27:0] s3_ax, s3_ay;
  logic signed [49:0] s4_a, s4_d;
  logic signed [51:0] s4_b, s4_c;
  logic signed [53:0] s5_sx, s5_sy;
  logic signed [38:0] s6_mx, s6_my;
  logic signed [55:0] s7_px, s7_py;

  logic signed [45:0] rxx, ryy, rxy;
  logic signed [53:0] rsx, rsy;
  logic signed [37:0] tx, ty;
  logic signed [55:0] rpx, rpy;
  logic signed [35:0] dpx, dpy;
  logic signed [36:0] wx, wy;
  logic               clip_x, clip_y;
  out_t               satx, saty;

  always_comb begin
    rxx = s1_pxx + 46'sd524288;
    ryy = s1_pyy + 46'sd524288;
    rxy = s1_pxy + 46'sd524288;
    rsx = s5_sx + 54'sd32768;
    rsy = s5_sy + 54'sd32768;
    tx  = rsx[53:16];
    ty  = rsy[53:16];
    rpx = s7_px + 56'sd524288;
    rpy = s7_py + 56'sd524288;
    dpx = rpx[55:20];
    dpy = rpy[55:20];
    wx  = $signed(37'(cam.center_x)) + 37'(dpx);
    wy  = $signed(37'(cam.center_y)) - 37'(dpy);
    clip_x = 1'b1;
    if (wx > 37'sd32767) begin
      satx = 16'sh7fff;
    end else if (wx < -37'sd32768) begin
      satx = 16'sh8000;
    end else begin
      satx = wx[OUT_W-1:0];
      clip_x = 1'b0;
    end
    clip_y = 1'b1;
    if (wy > 37'sd32767) begin
      saty = 16'sh7fff;
    end else if (wy < -37'sd32768) begin
      saty = 16'sh8000;
    end else begin
      saty = wy[OUT_W-1:0];
      clip_y = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[5:0], in_valid};
      out_valid <= vld[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clp    <= {clp[5:0], in_clip};
      s1_nx  <= nx;
      s1_ny  <= ny;
      s1_pxx <= nx * nx;
      s1_pyy <= ny * ny;
      s1_pxy <= nx * ny;
      s2_nx  <= s1_nx;
      s2_ny  <= s1_ny;
      s2_x2  <= rxx[45:20];
      s2_y2  <= ryy[45:20];
      s2_xy  <= rxy[45:20];
      s3_nx  <= s2_nx;
      s3_ny  <= s2_ny;
      // r2 + 2 x2 and r2 + 2 y2
      s3_ax  <= (28'(s2_x2) <<< 1) + 28'(s2_x2) + 28'(s2_y2);
      s3_ay  <= (28'(s2_y2) <<< 1) + 28'(s2_y2) + 28'(s2_x2);
      s3_xy  <= s2_xy;
      s4_nx  <= s3_nx;
      s4_ny  <= s3_ny;
      s4_a   <= $signed(cam.p1) * s3_xy;
      s4_b   <= $signed(cam.p2) * s3_ax;
      s4_c   <= $signed(cam.p1) * s3_ay;
      s4_d   <= $signed(cam.p2) * s3_xy;
      s5_nx  <= s4_nx;
      s5_ny  <= s4_ny;
      s5_sx  <= (54'(s4_a) <<< 1) + 54'(s4_b);
      s5_sy  <= 54'(s4_c) + (54'(s4_d) <<< 1);
      s6_mx  <= 39'(s5_nx) + 39'(tx);
      s6_my  <= 39'(s5_ny) + 39'(ty);
      s7_px  <= s6_mx * fs;
      s7_py  <= s6_my * fs;
      ox       <= satx;
      oy       <= saty;
      out_clip <= clp[6] | clip_x | clip_y;
    end
  end

endmodule

>>> rtl/lens_distortion_point_map_top.sv
// ----------------------------------------------------------------------------
// lens_distortion_point_map_top
// Maps an integer pixel to its lens corrected position in 1/16 pixel units.
//
// Input channel in_valid/in_stall carries pix_x, pix_y; output channel
// out_valid/out_stall carries out_x, out_y and clipped. A transfer happens on
// a clock edge with valid high and stall low. The config channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; indexes 0..7
// are center_x, center_y, focal_len, k1, k2, k3, p1, p2, others are dropped.
// Write config only while the pipeline is empty.
// One point per cycle unless the output stalls. Pipeline: two 26 stage
// normalizers (one quotient bit per stage), 13 radial and 8 tangential stages.
// A stalled output freezes the whole pipeline and in_stall follows, so no
// point is lost or repeated; bubbles are carried as invalid slots.
// Reset empties the pipeline and loads the default camera model.
// ----------------------------------------------------------------------------
module lens_distortion_point_map_top #(
  parameter int COORD_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [COORD_BITS-1:0]       pix_x,
  input  logic [COORD_BITS-1:0]       pix_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ldpm_pkg::out_t              out_x,
  output ldpm_pkg::out_t              out_y,
  output logic                        clipped,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ldpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ldpm_pkg::COEF_W-1:0] cfg_data
);
  import ldpm_pkg::*;

  center_t center_x, center_y;
  focal_t  focal_len;
  coef_t   radial_k1, radial_k2, radial_k3, tangent_p1, tangent_p2;
  cam_t    cam;
  logic    en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= 14'd2560;
      center_y   <= 14'd1920;
      focal_len  <= 16'd4096;
      radial_k1  <= '0;
      radial_k2  <= '0;
      radial_k3  <= '0;
      tangent_p1 <= '0;
      tangent_p2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: center_x   <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y: center_y   <= cfg_data[CENTER_W-1:0];
        REG_FOCAL:    focal_len  <= cfg_data[FOCAL_W-1:0];
        REG_K1:       radial_k1  <= cfg_data;
        REG_K2:       radial_k2  <= cfg_data;
        REG_K3:       radial_k3  <= cfg_data;
        REG_P1:       tangent_p1 <= cfg_data;
        REG_P2:       tangent_p2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero focal length behaves as one
  always_comb begin
    cam.center_x = center_x;
    cam.center_y = center_y;
    cam.focal    = (focal_len == '0) ? focal_t'(1) : focal_len;
    cam.k1       = radial_k1;
    cam.k2       = radial_k2;
    cam.k3       = radial_k3;
    cam.p1       = tangent_p1;
    cam.p2       = tangent_p2;
  end

  // pipeline moves unless a finished point is held by the receiver
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic signed [19:0] d1x, d1y;
  assign d1x = $signed(20'({pix_x, 4'b0})) - $signed(20'(center_x));
  assign d1y = $signed(20'(center_y)) - $signed(20'({pix_y, 4'b0}));

  logic  n1_valid, n1_clip;
  norm_t n1x, n1y;

  ldpm_norm #(.DW(20)) u_norm1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_clip   (1'b0),
    .dx        (d1x),
    .dy        (d1y),
    .f         (cam.focal),
    .out_valid (n1_valid),
    .out_clip  (n1_clip),
    .nx        (n1x),
    .ny        (n1y)
  );

  logic rad_valid, rad_clip;
  mid_t rad_x, rad_y;

  ldpm_radial u_radial (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cam       (cam),
    .in_valid  (n1_valid),
    .in_clip   (n1_clip),
    .nx        (n1x),
    .ny        (n1y),
    .out_valid (rad_valid),
    .out_clip  (rad_clip),
    .mx        (rad_x),
    .my        (rad_y)
  );

  logic signed [24:0] d2x, d2y;
  assign d2x = 25'(rad_x) - $signed(25'(center_x));
  assign d2y = $signed(25'(center_y)) - 25'(rad_y);

  logic  n2_valid, n2_clip;
  norm_t n2x, n2y;

  ldpm_norm #(.DW(25)) u_norm2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rad_valid),
    .in_clip   (rad_clip),
    .dx        (d2x),
    .dy        (d2y),
    .f         (cam.focal),
    .out_valid (n2_valid),
    .out_clip  (n2_clip),
    .nx        (n2x),
    .ny        (n2y)
  );

  ldpm_tangent u_tangent (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cam       (cam),
    .in_valid  (n2_valid),
    .in_clip   (n2_clip),
    .nx        (n2x),
    .ny        (n2y),
    .out_valid (out_valid),
    .out_clip  (clipped),
    .ox        (out_x),
    .oy        (out_y)
  );

endmodule
